>>> src/sfd_pkg.sv
// Shared constants and types for the speed filter (dead zone, hysteresis,
// moving average, slew limit, clamp). No dependencies.
package sfd_pkg;

    localparam int DATA_W     = 16;
    localparam int WINDOW     = 8;
    localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int SUM_W      = DATA_W + $clog2(WINDOW);
    localparam int QCNT_W     = $clog2(SUM_W + 1);
    localparam int CFG_ADDR_W = 3;

    localparam logic [DATA_W-1:0] RST_DEAD_ZONE   = DATA_W'(32);
    localparam logic [DATA_W-1:0] RST_START_LEVEL = DATA_W'(48);
    localparam logic [DATA_W-1:0] RST_STOP_LEVEL  = DATA_W'(24);
    localparam logic [DATA_W-1:0] RST_MAX_CHANGE  = DATA_W'(240);
    localparam logic [DATA_W-1:0] RST_MAX_SPEED   = DATA_W'(3840);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DEAD_ZONE   = 3'd0,
        REG_START_LEVEL = 3'd1,
        REG_STOP_LEVEL  = 3'd2,
        REG_MAX_CHANGE  = 3'd3,
        REG_MAX_SPEED   = 3'd4
    } t_cfg_reg;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_DIV  = 5'b00100,
        S_SLEW = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

endpackage

>>> src/sfd_div.sv
// Bit-serial restoring divider: running sum by sample count, one quotient
// bit per cycle. Depends on sfd_pkg.
module sfd_div import sfd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [SUM_W-1:0]  r_quo;   // dividend shifts out at the top, quotient in at the bottom
    logic [CNT_W:0]    w_sh;
    logic              w_ge;
    logic [CNT_W:0]    w_diff;

    assign w_sh   = {r_rem, r_quo[SUM_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= QCNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == QCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_sh[CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

endmodule

>>> src/speed_filter_deadzone_avg_slew_top.sv
// Speed filter top: dead zone, moving hysteresis, WINDOW-sample running
// average (serial divide), slew limit and clamp. Depends on sfd_pkg, sfd_div.
//
//  port group     dir  payload                              handshake
//  i_s_*          in   tdata[15:0] raw_speed                tvalid/tready
//  o_m_*          out  tdata[15:0] filtered_speed,          tvalid/tready
//                      tuser[0] moving
//  i_cfg_*        in   addr = register index, wdata[15:0]   we, no wait
//
// A request passes through S_SUM, S_DIV (the bit-serial divider, one quotient
// bit per cycle), S_SLEW and S_OUT between accept and result.
// tready is high only in S_IDLE, which is reached once the previous result
// sits in the output register; no new request is taken while one is in flight.
// Reset is synchronous, active low; the sample ring holds no reset value.
// A stalled output holds the finished result and the next one waits in S_OUT.
module speed_filter_deadzone_avg_slew_top import sfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [DATA_W-1:0]     i_s_tdata,    // [15:0] raw_speed
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [DATA_W-1:0]     o_m_tdata,    // [15:0] filtered_speed
    output logic                  o_m_tuser,    // [0] moving
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DATA_W-1:0]     i_cfg_wdata
);

    t_state            r_state;
    logic [DATA_W-1:0] r_dead_zone, r_start_level, r_stop_level, r_max_change, r_max_speed;
    logic              r_flag;
    logic [DATA_W-1:0] r_v;
    logic [DATA_W-1:0] r_ring [WINDOW];
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic [DATA_W-1:0] r_last;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_moving;

    logic              w_accept;
    logic [DATA_W-1:0] w_dz;
    logic              n_flag;
    logic [DATA_W-1:0] n_v;
    logic              w_full;
    logic [SUM_W-1:0]  n_sum;
    logic [CNT_W-1:0]  n_count;
    logic [POS_W-1:0]  n_pos;
    logic              w_div_done;
    logic [SUM_W-1:0]  w_quo;
    logic [DATA_W-1:0] w_avg;
    logic [DATA_W:0]   w_up;
    logic [DATA_W:0]   w_avg_mc;
    logic [DATA_W:0]   w_lim;
    logic [DATA_W-1:0] n_last;
    logic              w_can_load;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // dead zone then hysteresis; zero passes while stationary
    always_comb begin
        w_dz   = (i_s_tdata < r_dead_zone) ? '0 : i_s_tdata;
        n_flag = r_flag;
        n_v    = '0;
        if (!r_flag && w_dz >= r_start_level) begin
            n_flag = 1'b1;
            n_v    = w_dz;
        end else if (r_flag && w_dz <= r_stop_level) begin
            n_flag = 1'b0;
        end else if (r_flag) begin
            n_v = w_dz;
        end
    end

    assign w_full  = (r_count == CNT_W'(WINDOW));
    assign n_sum   = r_sum - (w_full ? SUM_W'(r_ring[r_pos]) : '0) + SUM_W'(r_v);
    assign n_count = w_full ? r_count : r_count + 1'b1;
    assign n_pos   = (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;

    sfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SUM),
        .i_dividend (n_sum),
        .i_divisor  (n_count),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // mean fits in DATA_W bits as it never exceeds the largest sample
    assign w_avg    = w_quo[DATA_W-1:0];
    assign w_up     = {1'b0, r_last} + {1'b0, r_max_change};
    assign w_avg_mc = {1'b0, w_avg} + {1'b0, r_max_change};

    always_comb begin
        if ({1'b0, w_avg} > w_up)
            w_lim = w_up;
        else if (w_avg_mc < {1'b0, r_last})
            w_lim = {1'b0, r_last - r_max_change};   // positive here, no floor needed
        else
            w_lim = {1'b0, w_avg};
        n_last = (w_lim > {1'b0, r_max_speed}) ? r_max_speed : w_lim[DATA_W-1:0];
    end

    assign w_can_load = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (w_accept) r_state <= S_SUM;
                S_SUM:   r_state <= S_DIV;
                S_DIV:   if (w_div_done) r_state <= S_SLEW;
                S_SLEW:  r_state <= S_OUT;
                S_OUT:   if (w_can_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone   <= RST_DEAD_ZONE;
            r_start_level <= RST_START_LEVEL;
            r_stop_level  <= RST_STOP_LEVEL;
            r_max_change  <= RST_MAX_CHANGE;
            r_max_speed   <= RST_MAX_SPEED;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_DEAD_ZONE:   r_dead_zone   <= i_cfg_wdata;
                REG_START_LEVEL: r_start_level <= i_cfg_wdata;
                REG_STOP_LEVEL:  r_stop_level  <= i_cfg_wdata;
                REG_MAX_CHANGE:  r_max_change  <= i_cfg_wdata;
                REG_MAX_SPEED:   r_max_speed   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= 1'b0;
            r_pos   <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_last  <= '0;
        end else begin
            if (w_accept)
                r_flag <= n_flag;
            if (r_state == S_SUM) begin
                r_sum   <= n_sum;
                r_count <= n_count;
                r_pos   <= n_pos;
            end
            if (r_state == S_SLEW)
                r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept)
            r_v <= n_v;
        if (r_state == S_SUM)
            r_ring[r_pos] <= r_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_can_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_can_load) begin
            r_out_data   <= r_last;
            r_out_moving <= r_flag;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_moving;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SUM))
        else $error("accepted request did not move to sum update");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW))
        else $error("sample count beyond window");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == S_OUT))
        else $error("output raised without a finished request");

endmodule
